>>> rtl/core/nearest_polyline_segment_hit_unit_macros.svh
// Assertion macros for the top file, which checks its own logic.
`ifndef NEAREST_POLYLINE_SEGMENT_HIT_UNIT_MACROS_SVH
`define NEAREST_POLYLINE_SEGMENT_HIT_UNIT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define NPSH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npsh check failed");

// Checks that a condition implies a consequence in the next cycle.
`define NPSH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npsh check failed");

`endif

>>> rtl/core/npsh_pkg.sv
package npsh_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int PointBits = CoordBits + FracBits;
  localparam int DistBits  = 2 * PointBits + 2;
  // Edge vector and products.
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits + 1;
  // Unsigned dividend |tn| * |r| << FracBits and divisor |den|.
  localparam int DvdBits   = ProdBits + DiffBits + FracBits;
  localparam int DvsBits   = ProdBits;
  localparam int QuoBits   = PointBits + 1;
  localparam int CntBits   = $clog2(DvdBits + 1);
  localparam int QueueDepth = 2;

  localparam logic [1:0] RegStartX = 2'd0;
  localparam logic [1:0] RegStartY = 2'd1;
  localparam logic [1:0] RegEndX   = 2'd2;
  localparam logic [1:0] RegEndY   = 2'd3;

  // One edge task handed from the front to the back.
  typedef struct packed {
    logic                        first;
    logic                        last;
    logic                        test;
    logic signed [CoordBits-1:0] x0;
    logic signed [CoordBits-1:0] y0;
    logic signed [CoordBits-1:0] x1;
    logic signed [CoordBits-1:0] y1;
  } task_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PROD,
    BK_TEST,
    BK_MULX,
    BK_DIVX,
    BK_MULY,
    BK_DIVY,
    BK_DIST,
    BK_CMP,
    BK_OUT
  } bk_state_t;

endpackage

>>> rtl/core/npsh_front.sv
module npsh_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [npsh_pkg::CoordBits-1:0] vertex_x,
  input  logic signed [npsh_pkg::CoordBits-1:0] vertex_y,
  input  logic                                  first_vertex,
  input  logic                                  last_vertex,
  output logic                                  task_valid,
  output npsh_pkg::task_t                       task_word,
  input  logic                                  task_take
);

  localparam int PtrBits = $clog2(npsh_pkg::QueueDepth);

  npsh_pkg::task_t                       slots [npsh_pkg::QueueDepth];
  logic [PtrBits-1:0]                    wr_ptr;
  logic [PtrBits-1:0]                    rd_ptr;
  logic [PtrBits:0]                      count;
  logic signed [npsh_pkg::CoordBits-1:0] prev_x;
  logic signed [npsh_pkg::CoordBits-1:0] prev_y;
  logic                                  have_prev;
  logic                                  accept;
  npsh_pkg::task_t                       fresh;

  assign full       = (count == PtrBits'(0) + (PtrBits+1)'(npsh_pkg::QueueDepth));
  assign accept     = push && !full;
  assign task_valid = (count != '0);
  assign task_word  = slots[rd_ptr];

  // The edge test is classified here: only a vertex with a held predecessor
  // and no restart flag forms an edge.
  always_comb begin
    fresh.first = first_vertex;
    fresh.last  = last_vertex;
    fresh.test  = !first_vertex && have_prev;
    fresh.x0    = prev_x;
    fresh.y0    = prev_y;
    fresh.x1    = vertex_x;
    fresh.y1    = vertex_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
    end else begin
      if (accept) begin
        slots[wr_ptr] <= fresh;
        wr_ptr        <= wr_ptr + 1'b1;
        prev_x        <= vertex_x;
        prev_y        <= vertex_y;
        have_prev     <= !last_vertex;
      end
      if (task_take && task_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (accept ? 1'b1 : 1'b0) - ((task_take && task_valid) ? 1'b1 : 1'b0);
    end
  end

endmodule

>>> rtl/core/npsh_divider.sv
module npsh_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [npsh_pkg::DvdBits-1:0]        dividend,
  input  logic [npsh_pkg::DvsBits-1:0]        divisor,
  output logic                                busy,
  output logic                                done,
  output logic [npsh_pkg::QuoBits-1:0]        quotient
);

  logic [npsh_pkg::DvdBits-1:0] quo;
  logic [npsh_pkg::DvsBits:0]   rem;
  logic [npsh_pkg::CntBits-1:0] cnt;
  logic [npsh_pkg::DvsBits:0]   shifted;
  logic [npsh_pkg::DvsBits+1:0] trial;

  // Restoring division, one quotient bit a cycle.
  assign shifted  = {rem[npsh_pkg::DvsBits-1:0], quo[npsh_pkg::DvdBits-1]};
  assign trial    = {1'b0, shifted} - {2'b00, divisor};
  assign quotient = quo[npsh_pkg::QuoBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        cnt  <= npsh_pkg::CntBits'(npsh_pkg::DvdBits);
      end else if (busy) begin
        if (!trial[npsh_pkg::DvsBits+1]) begin
          rem <= trial[npsh_pkg::DvsBits:0];
          quo <= {quo[npsh_pkg::DvdBits-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[npsh_pkg::DvdBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == npsh_pkg::CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/npsh_back.sv
module npsh_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [npsh_pkg::CoordBits-1:0] s0x,
  input  logic signed [npsh_pkg::CoordBits-1:0] s0y,
  input  logic signed [npsh_pkg::CoordBits-1:0] s1x,
  input  logic signed [npsh_pkg::CoordBits-1:0] s1y,
  input  logic                                  task_valid,
  input  npsh_pkg::task_t                       task_word,
  output logic                                  task_take,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  hit,
  output logic signed [npsh_pkg::PointBits-1:0] point_x,
  output logic signed [npsh_pkg::PointBits-1:0] point_y
);

  localparam int D = npsh_pkg::DiffBits;
  localparam int P = npsh_pkg::ProdBits;
  localparam int Q = npsh_pkg::PointBits;

  npsh_pkg::bk_state_t state, state_next;
  npsh_pkg::task_t     cur;

  logic signed [D-1:0] rx, ry, ux, uy, dx, dy;
  logic signed [P-1:0] den, sn, tn;
  logic signed [Q-1:0] px, py;
  logic                found;
  logic signed [Q-1:0] best_x, best_y;
  logic [npsh_pkg::DistBits-1:0] best_dist, span_sq;
  logic [npsh_pkg::DistBits-1:0] sq_x;
  logic                          ok;
  logic                          neg_x, neg_y;
  logic [npsh_pkg::DvdBits-1:0]  dvd;
  logic [P-1:0]                  mag_tn, mag_den;
  logic [D-1:0]                  mag_r;
  logic signed [D-1:0]           r_sel;
  logic signed [Q:0]             ex, ey;
  logic [Q:0]                    mag_e;

  logic                          div_start, div_busy, div_done;
  logic [npsh_pkg::QuoBits-1:0]  div_q;
  logic signed [Q-1:0]           off;
  logic signed [Q-1:0]           base;

  function automatic logic in_unit(input logic signed [P-1:0] num,
                                   input logic signed [P-1:0] d);
    logic r;
    if (d > 0) r = (num >= 0) && (num <= d);
    else       r = (num <= 0) && (num >= d);
    return r;
  endfunction

  npsh_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (mag_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign empty = (state != npsh_pkg::BK_OUT);
  assign mag_tn  = tn[P-1] ? P'(-tn) : P'(tn);
  assign mag_den = den[P-1] ? P'(-den) : P'(den);
  assign r_sel   = (state == npsh_pkg::BK_MULX) ? rx : ry;
  assign mag_r   = r_sel[D-1] ? D'(-r_sel) : D'(r_sel);
  assign off     = (state == npsh_pkg::BK_DIVX ? neg_x : neg_y) ?
                   Q'(-$signed({1'b0, div_q})) : Q'(div_q);
  assign base    = (state == npsh_pkg::BK_DIVX) ?
                   Q'($signed(cur.x0)) <<< npsh_pkg::FracBits :
                   Q'($signed(cur.y0)) <<< npsh_pkg::FracBits;
  assign mag_e   = (state == npsh_pkg::BK_DIST) ?
                   (ex[Q] ? (Q+1)'(-ex) : (Q+1)'(ex)) :
                   (ey[Q] ? (Q+1)'(-ey) : (Q+1)'(ey));

  always_comb begin
    state_next = state;
    task_take  = 1'b0;
    div_start  = 1'b0;
    case (state)
      npsh_pkg::BK_IDLE: begin
        if (task_valid) begin
          task_take  = 1'b1;
          state_next = npsh_pkg::BK_PROD;
        end
      end
      npsh_pkg::BK_PROD: state_next = npsh_pkg::BK_TEST;
      npsh_pkg::BK_TEST: begin
        if (ok) state_next = npsh_pkg::BK_MULX;
        else state_next = cur.last ? npsh_pkg::BK_OUT : npsh_pkg::BK_IDLE;
      end
      npsh_pkg::BK_MULX: begin
        div_start  = 1'b1;
        state_next = npsh_pkg::BK_DIVX;
      end
      npsh_pkg::BK_DIVX: if (div_done) state_next = npsh_pkg::BK_MULY;
      npsh_pkg::BK_MULY: begin
        div_start  = 1'b1;
        state_next = npsh_pkg::BK_DIVY;
      end
      npsh_pkg::BK_DIVY: if (div_done) state_next = npsh_pkg::BK_DIST;
      npsh_pkg::BK_DIST: state_next = npsh_pkg::BK_CMP;
      npsh_pkg::BK_CMP:
        state_next = cur.last ? npsh_pkg::BK_OUT : npsh_pkg::BK_IDLE;
      npsh_pkg::BK_OUT: if (pop) state_next = npsh_pkg::BK_IDLE;
      default: state_next = npsh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= npsh_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      best_x    <= '0;
      best_y    <= '0;
      best_dist <= '0;
    end else begin
      case (state)
        npsh_pkg::BK_IDLE: begin
          if (task_valid) begin
            cur <= task_word;
            if (task_word.first) found <= 1'b0;
            rx <= D'(task_word.x1) - D'(task_word.x0);
            ry <= D'(task_word.y1) - D'(task_word.y0);
            dx <= D'(task_word.x0) - D'(s0x);
            dy <= D'(task_word.y0) - D'(s0y);
            ux <= D'(s1x) - D'(s0x);
            uy <= D'(s1y) - D'(s0y);
          end
        end
        npsh_pkg::BK_PROD: begin
          den <= P'(rx * uy) - P'(ux * ry);
          sn  <= P'(rx * dy) - P'(ry * dx);
          tn  <= P'(ux * dy) - P'(uy * dx);
        end
        npsh_pkg::BK_TEST: begin
          neg_x <= (tn[P-1] ^ rx[D-1]) ^ den[P-1];
          neg_y <= (tn[P-1] ^ ry[D-1]) ^ den[P-1];
        end
        npsh_pkg::BK_MULX, npsh_pkg::BK_MULY: ;
        npsh_pkg::BK_DIVX: if (div_done) begin
          px <= base + ((tn == 0 || rx == 0) ? '0 : off);
        end
        npsh_pkg::BK_DIVY: if (div_done) begin
          py <= base + ((tn == 0 || ry == 0) ? '0 : off);
          ex <= (Q+1)'(px) - ((Q+1)'($signed(s0x)) <<< npsh_pkg::FracBits);
        end
        npsh_pkg::BK_DIST: begin
          sq_x <= npsh_pkg::DistBits'(mag_e * mag_e);
          ey   <= (Q+1)'(py) - ((Q+1)'($signed(s0y)) <<< npsh_pkg::FracBits);
        end
        npsh_pkg::BK_CMP: begin
          if (!found || span_sq < best_dist) begin
            found     <= 1'b1;
            best_x    <= px;
            best_y    <= py;
            best_dist <= span_sq;
          end
        end
        npsh_pkg::BK_OUT: if (pop) found <= 1'b0;
        default: ;
      endcase
    end
  end

  // Second square adds onto the first.
  assign span_sq = sq_x + npsh_pkg::DistBits'(mag_e * mag_e);
  assign dvd     = npsh_pkg::DvdBits'(mag_tn * mag_r) << npsh_pkg::FracBits;

  // The hit decision is combinational on the registered products.
  assign ok = (den != 0) && in_unit(sn, den) && in_unit(tn, den) && cur.test;

  assign hit     = found;
  assign point_x = found ? best_x : '0;
  assign point_y = found ? best_y : '0;

endmodule

>>> rtl/core/nearest_polyline_segment_hit_unit.sv
// Nearest crossing of an open polyline with a query segment. Vertices are
// pushed one word at a time; each vertex after the first forms an edge with
// its predecessor, and the edge is tested exactly against the segment held in
// registers 0 to 3. A hit point is formed in Q.8 by two serial divisions of
// 60 quotient bits, each holding the edge unit until its quotient is done;
// an edge that misses, or a vertex that forms no edge, leaves the edge unit
// after the test state with no division. A two-word queue parts the vertex
// intake from the edge unit. A last vertex yields one result word, and the
// edge unit waits on that word until it is popped.
`include "nearest_polyline_segment_hit_unit_macros.svh"

module nearest_polyline_segment_hit_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [npsh_pkg::CoordBits-1:0] vertex_x,
  input  logic signed [npsh_pkg::CoordBits-1:0] vertex_y,
  input  logic                                  first_vertex,
  input  logic                                  last_vertex,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  hit,
  output logic signed [npsh_pkg::PointBits-1:0] point_x,
  output logic signed [npsh_pkg::PointBits-1:0] point_y,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [npsh_pkg::CoordBits-1:0]        cfg_data
);

  logic signed [npsh_pkg::CoordBits-1:0] s0x, s0y, s1x, s1y;
  logic            task_valid;
  logic            task_take;
  npsh_pkg::task_t task_word;

  // Query segment registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0x <= '0;
      s0y <= '0;
      s1x <= '0;
      s1y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        npsh_pkg::RegStartX: s0x <= cfg_data;
        npsh_pkg::RegStartY: s0y <= cfg_data;
        npsh_pkg::RegEndX:   s1x <= cfg_data;
        npsh_pkg::RegEndY:   s1y <= cfg_data;
        default: ;
      endcase
    end
  end

  npsh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .first_vertex (first_vertex),
    .last_vertex  (last_vertex),
    .task_valid   (task_valid),
    .task_word    (task_word),
    .task_take    (task_take)
  );

  npsh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .s0x        (s0x),
    .s0y        (s0y),
    .s1x        (s1x),
    .s1y        (s1y),
    .task_valid (task_valid),
    .task_word  (task_word),
    .task_take  (task_take),
    .empty      (empty),
    .pop        (pop),
    .hit        (hit),
    .point_x    (point_x),
    .point_y    (point_y)
  );

  // A word is never taken from an empty queue.
  `NPSH_ASSERT_IMP(a_take_valid, task_take, task_valid)
  // A result with no hit carries a zero point.
  `NPSH_ASSERT_IMP(a_zero_point, !empty && !hit, point_x == '0 && point_y == '0)
  // A popped result leaves the output empty next cycle.
  `NPSH_ASSERT_NEXT(a_pop_clears, !empty && pop, empty)

endmodule
